// ===== design/sha1_pkg.sv =====
// Shared types, constants and helpers of the SHA-1 engine.
`default_nettype none

package sha1_pkg;

  typedef logic [31:0] word_t;
  typedef logic [4:0][31:0] chain_t;

  // Round constants, one for each group of twenty rounds
  localparam word_t K_0_19  = 32'h5A827999;
  localparam word_t K_20_39 = 32'h6ED9EBA1;
  localparam word_t K_40_59 = 32'h8F1BBCDC;
  localparam word_t K_60_79 = 32'hCA62C1D6;

  // Initial chaining words; entry 0 is the least significant word
  localparam chain_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                               32'hEFCDAB89, 32'h67452301};

  localparam logic [7:0] PAD_BYTE      = 8'h80;
  localparam logic [7:0] ZERO_BYTE     = 8'h00;
  localparam logic [6:0] LAST_ROUND    = 7'd79;
  localparam logic [6:0] ROUND_20      = 7'd20;
  localparam logic [6:0] ROUND_40      = 7'd40;
  localparam logic [6:0] ROUND_60      = 7'd60;
  localparam logic [5:0] LAST_BYTE_POS = 6'd63;
  localparam logic [2:0] LAST_WORD_IDX = 3'd4;
  localparam logic [63:0] BYTE_BITS    = 64'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD
  } state_t;

  // Controls from the sequencer to the schedule and the round unit
  typedef struct packed {
    logic       shift_byte;
    logic [7:0] byte_val;
    logic       load;
    logic       step;
    logic [6:0] rnd;
  } ctl_t;

  function automatic word_t rotl(input word_t x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

endpackage

`default_nettype wire

// ===== design/sha1_in_if.sv =====
// Input channel: one message byte slot and an end-of-message mark per beat.
`default_nettype none

interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source (output valid, output data_byte, output byte_valid,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input byte_valid,
                  input end_of_message, output ready);
endinterface

`default_nettype wire

// ===== design/sha1_out_if.sv =====
// Result channel: one digest word per beat.
`default_nettype none

interface sha1_out_if;
  logic                valid;
  logic                ready;
  sha1_pkg::word_t     digest_word;
  logic [2:0]          word_index;
  logic                last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

`default_nettype wire

// ===== design/sha1_hash_engine.sv =====
// SHA-1 engine top level: sequencer, chaining words, bit count and digest buffer.
//
// The engine hashes a byte stream with SHA-1. A beat that carries no byte or a
// byte that does not complete a 64-byte block is taken without a stall. The beat
// that completes a block starts a compression on the single round unit, which
// does one round a cycle: the input is not ready while it runs the 80 rounds
// and then adds into the chaining words. An end-of-message beat starts padding,
// one pad byte per cycle up to the end of the block, followed by one or two
// compressions. The five digest words then leave through a buffer, one beat
// each, word 0 first; the next message may be fed while they drain, and only a
// second digest waits for the buffer to empty.
`default_nettype none

module sha1_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  sha1_in_if.sink     in_ch,
  sha1_out_if.source  out_ch
);

  sha1_pkg::state_t state_r, state_nxt;
  sha1_pkg::chain_t chain_r, chain_nxt;
  sha1_pkg::chain_t work;
  sha1_pkg::chain_t sums;
  sha1_pkg::chain_t dig_r, dig_nxt;
  sha1_pkg::ctl_t   ctl;
  sha1_pkg::word_t  w_t;

  logic [63:0] cnt_r, cnt_nxt;
  logic [63:0] len_sh;
  logic [6:0]  rnd_r, rnd_nxt;
  logic [5:0]  pad_pos_r, pad_pos_nxt;
  logic        pad_first_r, pad_first_nxt;
  logic        fin_r, fin_nxt;
  logic        pad_act_r, pad_act_nxt;
  logic        eom_pend_r, eom_pend_nxt;
  logic [2:0]  out_idx_r, out_idx_nxt;
  logic        out_busy_r, out_busy_nxt;
  logic        dig_load;
  logic        in_acc;
  logic        out_acc;
  logic [7:0]  pad_val;

  assign in_acc  = in_ch.valid & in_ch.ready;
  assign out_acc = out_ch.valid & out_ch.ready;

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      sums[i] = chain_r[i] + work[i];
    end
  end

  // Length bytes go out most significant first at block positions 56..63
  assign len_sh = cnt_r << {pad_pos_r[2:0], 3'b000};

  always_comb begin
    if (pad_first_r) begin
      pad_val = sha1_pkg::PAD_BYTE;
    end else if (fin_r && (&pad_pos_r[5:3])) begin
      pad_val = len_sh[63:56];
    end else begin
      pad_val = sha1_pkg::ZERO_BYTE;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    chain_nxt     = chain_r;
    cnt_nxt       = cnt_r;
    rnd_nxt       = rnd_r;
    pad_pos_nxt   = pad_pos_r;
    pad_first_nxt = pad_first_r;
    fin_nxt       = fin_r;
    pad_act_nxt   = pad_act_r;
    eom_pend_nxt  = eom_pend_r;
    dig_load      = 1'b0;
    ctl           = '0;
    ctl.rnd       = rnd_r;
    in_ch.ready   = 1'b0;

    unique case (state_r)
      sha1_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_acc) begin
          if (in_ch.byte_valid) begin
            ctl.shift_byte = 1'b1;
            ctl.byte_val   = in_ch.data_byte;
            cnt_nxt        = cnt_r + sha1_pkg::BYTE_BITS;
          end
          if (in_ch.byte_valid && (cnt_r[8:3] == sha1_pkg::LAST_BYTE_POS)) begin
            // Block full: compress first, pad afterwards if the message ends
            ctl.load     = 1'b1;
            state_nxt    = sha1_pkg::ST_ROUND;
            eom_pend_nxt = in_ch.end_of_message;
            pad_act_nxt  = 1'b0;
          end else if (in_ch.end_of_message) begin
            state_nxt     = sha1_pkg::ST_PAD;
            pad_pos_nxt   = cnt_nxt[8:3];
            pad_first_nxt = 1'b1;
            fin_nxt       = ~(&cnt_nxt[8:6]);
            pad_act_nxt   = 1'b1;
          end
        end
      end

      sha1_pkg::ST_PAD: begin
        ctl.shift_byte = 1'b1;
        ctl.byte_val   = pad_val;
        pad_pos_nxt    = pad_pos_r + 6'd1;
        pad_first_nxt  = 1'b0;
        if (pad_pos_r == sha1_pkg::LAST_BYTE_POS) begin
          ctl.load  = 1'b1;
          state_nxt = sha1_pkg::ST_ROUND;
        end
      end

      sha1_pkg::ST_ROUND: begin
        ctl.step = 1'b1;
        if (rnd_r == sha1_pkg::LAST_ROUND) begin
          rnd_nxt   = '0;
          state_nxt = sha1_pkg::ST_ADD;
        end else begin
          rnd_nxt = rnd_r + 7'd1;
        end
      end

      sha1_pkg::ST_ADD: begin
        if (!pad_act_r) begin
          chain_nxt = sums;
          if (eom_pend_r) begin
            state_nxt     = sha1_pkg::ST_PAD;
            pad_pos_nxt   = '0;
            pad_first_nxt = 1'b1;
            fin_nxt       = 1'b1;
            pad_act_nxt   = 1'b1;
            eom_pend_nxt  = 1'b0;
          end else begin
            state_nxt = sha1_pkg::ST_IDLE;
          end
        end else if (!fin_r) begin
          // Padding spilled over: the length block follows
          chain_nxt = sums;
          fin_nxt   = 1'b1;
          state_nxt = sha1_pkg::ST_PAD;
        end else if (!out_busy_r) begin
          dig_load    = 1'b1;
          chain_nxt   = sha1_pkg::H_INIT;
          cnt_nxt     = '0;
          pad_act_nxt = 1'b0;
          state_nxt   = sha1_pkg::ST_IDLE;
        end
        // else hold until the digest buffer drains
      end

      default: begin
        state_nxt = sha1_pkg::ST_IDLE;
      end
    endcase
  end

  // Digest buffer
  always_comb begin
    dig_nxt      = dig_r;
    out_idx_nxt  = out_idx_r;
    out_busy_nxt = out_busy_r;
    if (dig_load) begin
      dig_nxt      = sums;
      out_idx_nxt  = '0;
      out_busy_nxt = 1'b1;
    end else if (out_acc) begin
      if (out_idx_r == sha1_pkg::LAST_WORD_IDX) begin
        out_busy_nxt = 1'b0;
      end else begin
        out_idx_nxt = out_idx_r + 3'd1;
      end
    end
  end

  assign out_ch.valid       = out_busy_r;
  assign out_ch.digest_word = dig_r[out_idx_r];
  assign out_ch.word_index  = out_idx_r;
  assign out_ch.last_word   = (out_idx_r == sha1_pkg::LAST_WORD_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha1_pkg::ST_IDLE;
      chain_r     <= sha1_pkg::H_INIT;
      cnt_r       <= '0;
      rnd_r       <= '0;
      pad_pos_r   <= '0;
      pad_first_r <= 1'b0;
      fin_r       <= 1'b0;
      pad_act_r   <= 1'b0;
      eom_pend_r  <= 1'b0;
      out_idx_r   <= '0;
      out_busy_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chain_r     <= chain_nxt;
      cnt_r       <= cnt_nxt;
      rnd_r       <= rnd_nxt;
      pad_pos_r   <= pad_pos_nxt;
      pad_first_r <= pad_first_nxt;
      fin_r       <= fin_nxt;
      pad_act_r   <= pad_act_nxt;
      eom_pend_r  <= eom_pend_nxt;
      out_idx_r   <= out_idx_nxt;
      out_busy_r  <= out_busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
  end

  sha1_sched u_sched (
    .clk (clk),
    .ctl (ctl),
    .w_t (w_t)
  );

  sha1_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .chain (chain_r),
    .w_t   (w_t),
    .work  (work)
  );

  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    rnd_r <= sha1_pkg::LAST_ROUND)
    else $error("round counter out of range");

  a_rnd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != sha1_pkg::ST_ROUND |-> rnd_r == '0)
    else $error("round counter not cleared outside compression");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.byte_valid |=> cnt_r == $past(cnt_r) + sha1_pkg::BYTE_BITS)
    else $error("bit count did not advance by one byte");

  a_dig_free: assert property (@(posedge clk) disable iff (!rst_n)
    dig_load |-> !out_busy_r)
    else $error("digest loaded over undelivered words");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_busy_r |-> out_idx_r <= sha1_pkg::LAST_WORD_IDX)
    else $error("digest word index out of range");

endmodule

`default_nettype wire

// ===== design/sha1_sched.sv =====
// Block buffer and rolling 16-word message schedule.
`default_nettype none

module sha1_sched (
  input  logic             clk,
  input  sha1_pkg::ctl_t   ctl,
  output sha1_pkg::word_t  w_t
);

  // Word i (oldest first) sits at blk_r[511-32*i -: 32]
  logic [511:0] blk_r;
  logic [511:0] blk_nxt;
  sha1_pkg::word_t w0;
  sha1_pkg::word_t w2;
  sha1_pkg::word_t w8;
  sha1_pkg::word_t w13;

  assign w0  = blk_r[511:480];
  assign w2  = blk_r[447:416];
  assign w8  = blk_r[255:224];
  assign w13 = blk_r[95:64];

  // First sixteen rounds read the loaded words, then expand in place
  assign w_t = (ctl.rnd[6:4] == 3'd0) ? w0 : sha1_pkg::rotl(w0 ^ w2 ^ w8 ^ w13, 1);

  always_comb begin
    blk_nxt = blk_r;
    if (ctl.shift_byte) begin
      blk_nxt = {blk_r[503:0], ctl.byte_val};
    end else if (ctl.step) begin
      blk_nxt = {blk_r[479:0], w_t};
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

endmodule

`default_nettype wire

// ===== design/sha1_round.sv =====
// Working registers a..e and the one-round-per-cycle compression unit.
`default_nettype none

module sha1_round (
  input  logic              clk,
  input  logic              rst_n,
  input  sha1_pkg::ctl_t    ctl,
  input  sha1_pkg::chain_t  chain,
  input  sha1_pkg::word_t   w_t,
  output sha1_pkg::chain_t  work
);

  sha1_pkg::chain_t work_r;
  sha1_pkg::chain_t work_nxt;
  sha1_pkg::word_t  f_val;
  sha1_pkg::word_t  k_val;
  sha1_pkg::word_t  t_val;
  sha1_pkg::word_t  a;
  sha1_pkg::word_t  b;
  sha1_pkg::word_t  c;
  sha1_pkg::word_t  d;
  sha1_pkg::word_t  e;

  assign a = work_r[0];
  assign b = work_r[1];
  assign c = work_r[2];
  assign d = work_r[3];
  assign e = work_r[4];

  always_comb begin
    if (ctl.rnd < sha1_pkg::ROUND_20) begin
      f_val = (b & c) | (~b & d);
      k_val = sha1_pkg::K_0_19;
    end else if (ctl.rnd < sha1_pkg::ROUND_40) begin
      f_val = b ^ c ^ d;
      k_val = sha1_pkg::K_20_39;
    end else if (ctl.rnd < sha1_pkg::ROUND_60) begin
      f_val = (b & c) | (b & d) | (c & d);
      k_val = sha1_pkg::K_40_59;
    end else begin
      f_val = b ^ c ^ d;
      k_val = sha1_pkg::K_60_79;
    end
    t_val = sha1_pkg::rotl(a, 5) + f_val + e + k_val + w_t;
  end

  always_comb begin
    work_nxt = work_r;
    if (ctl.load) begin
      work_nxt = chain;
    end else if (ctl.step) begin
      work_nxt = {d, c, sha1_pkg::rotl(b, 30), a, t_val};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_r <= '0;
    end else begin
      work_r <= work_nxt;
    end
  end

  assign work = work_r;

endmodule

`default_nettype wire
